@@ rtl/gfd_pkg.sv @@
package gfd_pkg;

    localparam int unsigned PayloadLen = 8;
    localparam int unsigned IdxW       = $clog2(PayloadLen);

    localparam logic [7:0] StartByte  = 8'h0A;
    localparam logic [7:0] ByteOffset = 8'h20;
    localparam logic [7:0] Low6Mask   = 8'h3F;
    localparam logic [7:0] Low4Mask   = 8'h0F;
    localparam logic [7:0] RbHighMask = 8'h30;

    localparam logic [3:0] PhaseHunt  = 4'd0;
    localparam logic [3:0] PhaseFirst = 4'd1;
    localparam logic [3:0] PhaseCheck = 4'd9;

    typedef logic [PayloadLen-1:0][7:0] payload_t;

    // Framer status handed to the unpack stage.
    typedef struct packed {
        logic     good;
        logic     at_check;
        payload_t payload;
    } frame_stat_t;

endpackage

@@ rtl/gfd_framer.sv @@
module gfd_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output gfd_pkg::frame_stat_t stat
);

    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [7:0]        xor_reg;
    logic [7:0]        xor_next;
    gfd_pkg::payload_t store_reg;
    logic [7:0]        val;
    logic [gfd_pkg::IdxW-1:0] idx;
    logic              hunting;
    logic              in_payload;
    logic [3:0]        phase_minus1;

    assign val          = rx_byte - gfd_pkg::ByteOffset;
    assign phase_minus1 = phase_reg - gfd_pkg::PhaseFirst;
    assign idx          = phase_minus1[gfd_pkg::IdxW-1:0];
    assign hunting      = (phase_reg == gfd_pkg::PhaseHunt) || (phase_reg > gfd_pkg::PhaseCheck);
    assign in_payload   = !hunting && (phase_reg < gfd_pkg::PhaseCheck);

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        if (accept)
        begin
            if (hunting)
            begin
                if (rx_byte == gfd_pkg::StartByte)
                begin
                    phase_next = gfd_pkg::PhaseFirst;
                    xor_next   = 8'd0;
                end
                else
                begin
                    phase_next = gfd_pkg::PhaseHunt;
                end
            end
            else if (in_payload)
            begin
                phase_next = phase_reg + 4'd1;
                xor_next   = xor_reg ^ val;
            end
            else
            begin
                phase_next = gfd_pkg::PhaseHunt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gfd_pkg::PhaseHunt;
            xor_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_payload)
        begin
            store_reg[idx] <= val;
        end
    end

    assign stat.at_check = (phase_reg == gfd_pkg::PhaseCheck);
    assign stat.good     = accept && stat.at_check && (val == xor_reg);
    assign stat.payload  = store_reg;

endmodule

@@ rtl/gfd_unpack.sv @@
module gfd_unpack
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gfd_pkg::frame_stat_t stat,
    input  logic                 frame_ready,
    output logic                 frame_valid,
    output logic [15:0]          buttons,
    output logic [15:0]          pressed_mask,
    output logic [15:0]          released_mask,
    output logic [7:0]           left_axis_a,
    output logic [7:0]           left_axis_b,
    output logic [7:0]           right_axis_a,
    output logic [7:0]           right_axis_b
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] last_buttons_reg;
    logic [15:0] btn_reg;
    logic [15:0] press_reg;
    logic [15:0] rel_reg;
    logic [7:0]  la_reg;
    logic [7:0]  lb_reg;
    logic [7:0]  ra_reg;
    logic [7:0]  rb_reg;

    logic [15:0] btn_next;
    logic [7:0]  la_next;
    logic [7:0]  lb_next;
    logic [7:0]  ra_next;
    logic [7:0]  rb_next;
    logic [7:0]  p0, p1, p2, p3, p4, p5, p6, p7;
    logic [7:0]  b0, b1, b2;

    assign p0 = stat.payload[0];
    assign p1 = stat.payload[1];
    assign p2 = stat.payload[2];
    assign p3 = stat.payload[3];
    assign p4 = stat.payload[4];
    assign p5 = stat.payload[5];
    assign p6 = stat.payload[6];
    assign p7 = stat.payload[7];

    assign b0 = p0 & gfd_pkg::Low6Mask;
    assign b1 = p1 & gfd_pkg::Low6Mask;
    assign b2 = p2 & gfd_pkg::Low4Mask;

    assign btn_next = {b2[3:0], b1[5:0], b0[5:0]};
    assign la_next  = p3 | (p4 << 6);
    assign lb_next  = (p4 >> 2) | (p5 << 4);
    assign ra_next  = (p5 >> 4) | (p6 << 2);
    assign rb_next  = p7 | ((p2 & gfd_pkg::RbHighMask) << 2);

    // A good frame only arrives when the result register is free or draining.
    assign valid_next = stat.good ? 1'b1 : (frame_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            last_buttons_reg <= 16'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (stat.good)
            begin
                last_buttons_reg <= btn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.good)
        begin
            btn_reg   <= btn_next;
            press_reg <= btn_next & ~last_buttons_reg;
            rel_reg   <= ~btn_next & last_buttons_reg;
            la_reg    <= la_next;
            lb_reg    <= lb_next;
            ra_reg    <= ra_next;
            rb_reg    <= rb_next;
        end
    end

    assign frame_valid   = valid_reg;
    assign buttons       = btn_reg;
    assign pressed_mask  = press_reg;
    assign released_mask = rel_reg;
    assign left_axis_a   = la_reg;
    assign left_axis_b   = lb_reg;
    assign right_axis_a  = ra_reg;
    assign right_axis_b  = rb_reg;

endmodule

@@ rtl/gamepad_frame_decoder.sv @@
// Gamepad frame decoder.
// The rx channel (rx_valid, rx_ready, rx_byte) takes one received serial word
// per cycle. The block hunts for the start byte, collects eight payload bytes
// and a check byte, and on a good check presents one frame word on the frame
// channel (frame_valid, frame_ready) with the button bits, press and release
// edge masks against the previous good frame, and four stick axes.
// Bad frames are dropped and produce nothing.
// Throughput: one rx word per cycle. Latency: the frame word is valid in the
// cycle after its check byte is accepted; the framer and unpack logic sit
// between the framer state registers and the result register.
// When the receiver stalls, the result register holds its word; rx words are
// still taken, except a check byte, which waits until the result register is
// free or being drained in the same cycle.
// Reset clears the framer to hunting, the running check and the previous
// button state; no frame word is valid after reset.
module gamepad_frame_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [15:0] buttons,
    output logic [15:0] pressed_mask,
    output logic [15:0] released_mask,
    output logic [7:0]  left_axis_a,
    output logic [7:0]  left_axis_b,
    output logic [7:0]  right_axis_a,
    output logic [7:0]  right_axis_b
);

    gfd_pkg::frame_stat_t stat;
    logic                 accept;

    assign rx_ready = !stat.at_check || !frame_valid || frame_ready;
    assign accept   = rx_valid && rx_ready;

    gfd_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .stat    (stat)
    );

    gfd_unpack u_unpack
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .stat          (stat),
        .frame_ready   (frame_ready),
        .frame_valid   (frame_valid),
        .buttons       (buttons),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .left_axis_a   (left_axis_a),
        .left_axis_b   (left_axis_b),
        .right_axis_a  (right_axis_a),
        .right_axis_b  (right_axis_b)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.good |-> (!frame_valid || frame_ready))
        else $error("good frame would overwrite an unread result");

    a_good_shows: assert property (@(posedge clk) disable iff (!rst_n)
        stat.good |=> frame_valid)
        else $error("good frame did not reach the result register");

    a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> ((pressed_mask & released_mask) == 16'd0))
        else $error("press and release masks overlap");

    a_press_subset: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> ((pressed_mask & ~buttons) == 16'd0))
        else $error("pressed mask marks a released button");
`endif

endmodule

@@ tb/gamepad_frame_decoder_checker.sv @@
module gamepad_frame_decoder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_valid,
    input  logic        frame_ready,
    input  logic [15:0] buttons,
    input  logic [15:0] pressed_mask,
    input  logic [15:0] released_mask,
    input  logic [7:0]  left_axis_a,
    input  logic [7:0]  left_axis_b,
    input  logic [7:0]  right_axis_a,
    input  logic [7:0]  right_axis_b,
    output int          fail_count,
    output int          frames_pending,
    output int          frames_predicted,
    output int          frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] buttons;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [7:0]  left_a;
        logic [7:0]  left_b;
        logic [7:0]  right_a;
        logic [7:0]  right_b;
    } frame_word_t;

    logic [3:0]  phase;
    logic [7:0]  store [gfd_pkg::PayloadLen];
    logic [7:0]  xor_acc;
    logic [15:0] prev_buttons;
    frame_word_t expected_frames [$];

    function automatic frame_word_t unpack_frame();
        frame_word_t w;
        w.buttons  = 16'(store[0] & gfd_pkg::Low6Mask)
                   | (16'(store[1] & gfd_pkg::Low6Mask) << 6)
                   | (16'(store[2] & gfd_pkg::Low4Mask) << 12);
        w.pressed  = w.buttons & ~prev_buttons;
        w.released = ~w.buttons & prev_buttons;
        w.left_a   = store[3] | (store[4] << 6);
        w.left_b   = (store[4] >> 2) | (store[5] << 4);
        w.right_a  = (store[5] >> 4) | (store[6] << 2);
        w.right_b  = store[7] | ((store[2] & gfd_pkg::RbHighMask) << 2);
        return w;
    endfunction

    task automatic absorb_byte(input logic [7:0] raw);
        logic [7:0]  val;
        frame_word_t w;
        val = raw - gfd_pkg::ByteOffset;
        if (phase == gfd_pkg::PhaseHunt || phase > gfd_pkg::PhaseCheck)
        begin
            if (raw == gfd_pkg::StartByte)
            begin
                xor_acc = '0;
                phase   = gfd_pkg::PhaseFirst;
            end
            else
            begin
                phase = gfd_pkg::PhaseHunt;
            end
        end
        else if (phase < gfd_pkg::PhaseCheck)
        begin
            // A start value here is plain data; it never restarts the frame.
            store[gfd_pkg::IdxW'(phase - gfd_pkg::PhaseFirst)] = val;
            xor_acc = xor_acc ^ val;
            phase   = phase + 4'd1;
        end
        else
        begin
            if (val == xor_acc)
            begin
                w = unpack_frame();
                expected_frames.push_back(w);
                prev_buttons = w.buttons;
                frames_predicted++;
            end
            phase = gfd_pkg::PhaseHunt;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t w;
        if (!rst_n)
        begin
            phase        = gfd_pkg::PhaseHunt;
            xor_acc      = '0;
            prev_buttons = '0;
            expected_frames.delete();
            fail_count       = 0;
            frames_predicted = 0;
            frames_checked   = 0;
        end
        else
        begin
            // The word leaving now was predicted at an earlier edge, so the
            // output side is handled before the input side.
            if (frame_valid && frame_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("frame word with no frame pending: buttons %0h", buttons);
                    fail_count++;
                end
                else
                begin
                    w = expected_frames.pop_front();
                    check_field("buttons", w.buttons, buttons);
                    check_field("pressed_mask", w.pressed, pressed_mask);
                    check_field("released_mask", w.released, released_mask);
                    check_field("left_axis_a", 16'(w.left_a), 16'(left_axis_a));
                    check_field("left_axis_b", 16'(w.left_b), 16'(left_axis_b));
                    check_field("right_axis_a", 16'(w.right_a), 16'(right_axis_a));
                    check_field("right_axis_b", 16'(w.right_b), 16'(right_axis_b));
                    frames_checked++;
                end
            end
            if (rx_valid && rx_ready)
            begin
                absorb_byte(rx_byte);
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

@@ tb/gamepad_frame_decoder_tb.sv @@
module gamepad_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod   = 12;
    localparam int RandomBytes = 500;
    localparam int DrainCycles = 20;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        rx_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'h00;
    logic        frame_ready = 1'b0;
    logic        rx_ready;
    logic        frame_valid;
    logic [15:0] buttons;
    logic [15:0] pressed_mask;
    logic [15:0] released_mask;
    logic [7:0]  left_axis_a;
    logic [7:0]  left_axis_b;
    logic [7:0]  right_axis_a;
    logic [7:0]  right_axis_b;

    int fail_count;
    int frames_pending;
    int frames_predicted;
    int frames_checked;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int bytes_sent         = 0;

    gamepad_frame_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .frame_valid   (frame_valid),
        .frame_ready   (frame_ready),
        .buttons       (buttons),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .left_axis_a   (left_axis_a),
        .left_axis_b   (left_axis_b),
        .right_axis_a  (right_axis_a),
        .right_axis_b  (right_axis_b)
    );

    gamepad_frame_decoder_checker checker_i
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_valid         (rx_valid),
        .rx_ready         (rx_ready),
        .rx_byte          (rx_byte),
        .frame_valid      (frame_valid),
        .frame_ready      (frame_ready),
        .buttons          (buttons),
        .pressed_mask     (pressed_mask),
        .released_mask    (released_mask),
        .left_axis_a      (left_axis_a),
        .left_axis_b      (left_axis_b),
        .right_axis_a     (right_axis_a),
        .right_axis_b     (right_axis_b),
        .fail_count       (fail_count),
        .frames_pending   (frames_pending),
        .frames_predicted (frames_predicted),
        .frames_checked   (frames_checked)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    always @(posedge clk)
    begin
        frame_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_byte(input logic [7:0] value);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            rx_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        // Everything is settled at the falling edge, so ready seen there
        // holds at the next rising edge.
        @(negedge clk);
        while (!rx_ready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input gfd_pkg::payload_t payload, input bit spoil_check);
        logic [7:0] check;
        check = '0;
        send_byte(gfd_pkg::StartByte);
        for (int i = 0; i < gfd_pkg::PayloadLen; i++)
        begin
            send_byte(payload[i] + gfd_pkg::ByteOffset);
            check = check ^ payload[i];
        end
        if (spoil_check)
        begin
            check = check ^ 8'($urandom_range(255, 1));
        end
        send_byte(check + gfd_pkg::ByteOffset);
    endtask

    initial
    begin
        gfd_pkg::payload_t pl;
        int                pick;
        int                phase_end;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the raw word outside a frame.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Every payload word below the offset, so every subtraction wraps,
        // with a start value sitting in the middle of the payload.
        pl    = '1;
        pl[2] = gfd_pkg::StartByte - gfd_pkg::ByteOffset;
        send_frame(pl, 1'b0);
        // Start value as first payload word, and the check is wrong.
        pl    = '0;
        pl[0] = gfd_pkg::StartByte - gfd_pkg::ByteOffset;
        send_frame(pl, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 69;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 69;
                end
                default:
                begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            phase_end = bytes_sent + RandomBytes / 4;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                begin
                    repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
                end
                else if (pick == 1)
                begin
                    // Frame cut short; whatever follows lands in its payload.
                    send_byte(gfd_pkg::StartByte);
                    repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
                end
                else
                begin
                    pl = {$urandom, $urandom};
                    send_frame(pl, pick == 2);
                end
            end
        end

        rx_valid <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(negedge clk);
        while (frames_pending != 0) @(negedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d rx words over four pacing phases: free running, sender gaps,",
                 bytes_sent);
        $display("receiver stalls and both; %0d good frames predicted, %0d frame words checked.",
                 frames_predicted, frames_checked);
        if (fail_count == 0)
        begin
            $display("[gamepad_frame_decoder] OK");
        end
        else
        begin
            $display("[gamepad_frame_decoder] ERROR");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[gamepad_frame_decoder] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gfd_pkg.sv
rtl/gfd_framer.sv
rtl/gfd_unpack.sv
rtl/gamepad_frame_decoder.sv
tb/gamepad_frame_decoder_checker.sv
tb/gamepad_frame_decoder_tb.sv
